@@ hdl/lzd_pkg.sv @@
// Shared constants and controller/datapath interface types for the LZSS window decoder.
// No dependencies; imported by lzd_ctrl, lzd_datapath and lzss_window_decoder.
`default_nettype none

package lzd_pkg;

	// History window geometry
	localparam int WIN_AW    = 12;
	localparam int WIN_DEPTH = 1 << WIN_AW;
	localparam int MAX_MATCH = 18;
	localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(WIN_DEPTH - MAX_MATCH);

	// Match length bias and counter widths
	localparam int CNT_W      = 5;
	localparam logic [CNT_W-1:0] MATCH_BIAS = CNT_W'(3);
	localparam int FILL_W     = WIN_AW + 1;
	localparam int LEN_W      = 32;

	// Commands from controller to datapath
	typedef struct packed {
		logic start_frame;
		logic emit_lit;
		logic load_pos;
		logic start_copy;
		logic rd_en;
		logic emit_copy;
	} lzd_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic rem_zero;
		logic rem_one;
		logic olen_zero;
		logic pend;
		logic reads_zero;
		logic emit_last;
	} lzd_stat_t;

endpackage

`default_nettype wire

@@ hdl/lzd_ctrl.sv @@
// Controller of the LZSS window decoder: token parser and copy sequencer.
// Depends on lzd_pkg for the command and status types.
`default_nettype none

module lzd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       in_byte,
	input  wire logic             frame_start,
	input  wire lzd_pkg::lzd_stat_t stat,
	output lzd_pkg::lzd_cmd_t     cmd
);
	import lzd_pkg::*;

	typedef enum logic {ST_IDLE, ST_COPY} state_t;
	typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH_HI} phase_t;

	state_t      state_q, state_d;
	phase_t      phase_q, phase_d, ph_eff;
	logic [8:0]  flag_q, flag_d, flag_shr;
	logic        acc, active, flag_done, emit, ending;

	// Take an item only while idle and the output register can take a byte
	assign in_stall  = !(state_q == ST_IDLE && stat.out_free);
	assign acc       = in_valid && !in_stall;
	assign ph_eff    = frame_start ? PH_FLAG : phase_q;
	assign active    = frame_start ? !stat.olen_zero : !stat.rem_zero;
	assign flag_shr  = {1'b0, flag_q[8:1]};
	assign flag_done = (flag_shr[8:1] == 8'h00);

	// Decode the next step
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		flag_d  = flag_q;
		emit    = 1'b0;
		ending  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd.start_frame = frame_start;
					if (frame_start) begin
						phase_d = PH_FLAG;
						flag_d  = '0;
					end
					if (active) begin
						case (ph_eff)
							PH_FLAG: begin
								flag_d  = {1'b1, in_byte};
								phase_d = PH_TOKEN;
							end
							PH_TOKEN: begin
								if (flag_q[0]) begin
									cmd.emit_lit = 1'b1;
									flag_d       = flag_shr;
									phase_d      = flag_done ? PH_FLAG : PH_TOKEN;
								end else begin
									cmd.load_pos = 1'b1;
									phase_d      = PH_MATCH_HI;
								end
							end
							PH_MATCH_HI: begin
								cmd.start_copy = 1'b1;
								flag_d         = flag_shr;
								phase_d        = flag_done ? PH_FLAG : PH_TOKEN;
								state_d        = ST_COPY;
							end
							default: begin
								phase_d = PH_FLAG;
							end
						endcase
					end
				end
			end
			ST_COPY: begin
				// Emit a fetched byte, keep one read in flight
				emit          = stat.pend && stat.out_free;
				ending        = emit && (stat.emit_last || stat.rem_one);
				cmd.emit_copy = emit;
				cmd.rd_en     = (!stat.pend || emit) && !stat.reads_zero && !ending;
				if (ending || (!stat.pend && stat.reads_zero)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_FLAG;
			flag_q  <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			flag_q  <= flag_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/lzd_datapath.sv @@
// Datapath of the LZSS window decoder: history window, counters and output register.
// Depends on lzd_pkg for constants and the command and status types.
`default_nettype none

module lzd_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [lzd_pkg::LEN_W-1:0] cfg_data,
	input  wire lzd_pkg::lzd_cmd_t        cmd,
	output lzd_pkg::lzd_stat_t            stat,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_byte,
	output logic                          last_of_run,
	output logic                          stream_end
);
	import lzd_pkg::*;

	logic [7:0]        mem [WIN_DEPTH];
	logic [7:0]        mem_q, byp_q, copy_byte, emit_byte;
	logic              hit_q, vld_q, emit, emit_end, rd_old;
	logic [LEN_W-1:0]  olen_q, rem_q;
	logic [WIN_AW-1:0] wp_q, src_q, rd_off;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        pos_low_q;
	logic [CNT_W-1:0]  reads_q, emits_q, copy_len;
	logic              pend_q;
	logic              out_valid_q, last_q, end_q;
	logic [7:0]        out_byte_q;

	assign cfg_ready = 1'b1;

	// Select the byte to emit; unwritten window entries read as zero
	assign copy_byte = hit_q ? byp_q : (vld_q ? mem_q : 8'h00);
	assign emit      = cmd.emit_lit || cmd.emit_copy;
	assign emit_byte = cmd.emit_lit ? in_byte : copy_byte;
	assign emit_end  = cmd.emit_lit ? 1'b1 : (emits_q == CNT_W'(1) || rem_q == LEN_W'(1));
	assign rd_off    = src_q - WP_START;
	assign rd_old    = {1'b0, rd_off} < fill_q;
	assign copy_len  = CNT_W'(in_byte[3:0]) + MATCH_BIAS;

	// Report status
	always_comb begin
		stat.out_free   = !out_valid_q || !out_stall;
		stat.rem_zero   = (rem_q == '0);
		stat.rem_one    = (rem_q == LEN_W'(1));
		stat.olen_zero  = (olen_q == '0);
		stat.pend       = pend_q;
		stat.reads_zero = (reads_q == '0);
		stat.emit_last  = (emits_q == CNT_W'(1));
	end

	// Window memory: write the emitted byte, registered read-first port
	always_ff @(posedge clk) begin
		if (emit) begin
			mem[wp_q] <= emit_byte;
		end
		if (cmd.rd_en) begin
			mem_q <= mem[src_q];
		end
	end

	// Capture bypass and fill information with each read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			hit_q <= emit && (src_q == wp_q);
			byp_q <= emit_byte;
			vld_q <= rd_old;
		end
	end

	// Match source and token low byte
	always_ff @(posedge clk) begin
		if (cmd.load_pos) begin
			pos_low_q <= in_byte;
		end
		if (cmd.start_copy) begin
			src_q <= {in_byte[7:4], pos_low_q};
		end else if (cmd.rd_en) begin
			src_q <= src_q + WIN_AW'(1);
		end
	end

	// Frame counters, write pointer and copy counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q  <= '0;
			rem_q   <= '0;
			wp_q    <= WP_START;
			fill_q  <= '0;
			reads_q <= '0;
			emits_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				olen_q <= cfg_data;
			end
			if (cmd.start_frame) begin
				rem_q  <= olen_q;
				wp_q   <= WP_START;
				fill_q <= '0;
			end else if (emit) begin
				rem_q <= rem_q - LEN_W'(1);
				wp_q  <= wp_q + WIN_AW'(1);
				if (fill_q != FILL_W'(WIN_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (cmd.start_copy) begin
				reads_q <= copy_len;
				emits_q <= copy_len;
				pend_q  <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					reads_q <= reads_q - CNT_W'(1);
				end
				if (cmd.emit_copy) begin
					emits_q <= emits_q - CNT_W'(1);
				end
				if (cmd.rd_en) begin
					pend_q <= 1'b1;
				end else if (cmd.emit_copy) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_end;
			end_q      <= (rem_q == LEN_W'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign stream_end  = end_q;

endmodule

`default_nettype wire

@@ hdl/lzss_window_decoder.sv @@
// LZSS decoder with a 4096-byte history window. A flag or first match byte is taken by the
// parser; a literal is accepted and registered in the output register; a match's second byte
// starts a copy of 3..18 bytes, at one per cycle while the output is not stalled, through the
// window's registered read port. The input stalls until the copy is done.
// arst_n clears control state; the window needs no clearing since a fill count
// masks entries not yet written in the current frame.
`default_nettype none

module lzss_window_decoder (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     frame_start,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_byte,
	output logic                          last_of_run,
	output logic                          stream_end,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [lzd_pkg::LEN_W-1:0] cfg_data
);
	import lzd_pkg::*;

	lzd_cmd_t  cmd;
	lzd_stat_t stat;

	lzd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.frame_start (frame_start),
		.stat        (stat),
		.cmd         (cmd)
	);

	lzd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_byte     (in_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.stream_end  (stream_end)
	);

`ifndef NO_ASSERTIONS
	// The byte that ends the stream always closes its item's run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> last_of_run)
		else $error("stream_end without last_of_run");

	// Window reads only happen while no input item is taken
	a_rd_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> in_stall)
		else $error("window read during input accept");

	// A literal and a copied byte never compete for the output register
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_lit && cmd.emit_copy))
		else $error("two emits in one cycle");

	// An emit always finds the output register free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_lit || cmd.emit_copy) |-> stat.out_free)
		else $error("emit into a stalled output register");
`endif

endmodule

`default_nettype wire
